[rtl/bbd_agc_pkg.sv]
`default_nettype none
package bbd_agc_pkg;

   localparam int MAG_W      = 24;
   localparam int GAIN_W     = 32;
   localparam int FACTOR_W   = 17;
   localparam int LEVEL_W    = 8;
   localparam int NUM_BANDS  = 5;
   localparam int BAND_W     = 3;
   localparam int DIV_STEPS  = 8;
   localparam int DIV_W      = 3;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD_RATIO = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REFRACTORY_MS   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SQUELCH_LEVEL   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_TARGET    = 8'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_UP         = 8'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_DOWN       = 8'd5;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_MAX        = 8'd6;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_INITIAL    = 8'd7;

   localparam logic [9:0]          RST_THRESHOLD_RATIO = 10'd358;
   localparam logic [15:0]         RST_REFRACTORY_MS   = 16'd200;
   localparam logic [15:0]         RST_SQUELCH_LEVEL   = 16'd52;
   localparam logic [7:0]          RST_LEVEL_TARGET    = 8'd22;
   localparam logic [FACTOR_W-1:0] RST_GAIN_UP         = 17'd66847;
   localparam logic [FACTOR_W-1:0] RST_GAIN_DOWN       = 17'd61604;
   localparam logic [GAIN_W-1:0]   RST_GAIN_MAX        = 32'd3276800000;
   localparam logic [GAIN_W-1:0]   RST_GAIN_INITIAL    = 32'd3932160;
   localparam logic [GAIN_W-1:0]   GAIN_ONE            = 32'd65536;

   localparam logic [LEVEL_W-1:0] STRENGTH_MIN = 8'd32;
   localparam logic [LEVEL_W-1:0] STRENGTH_MAX = 8'd255;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 8'd255;

   typedef struct packed {
      logic [MAG_W-1:0] bass_magnitude;
      logic [MAG_W-1:0] band_mag_0;
      logic [MAG_W-1:0] band_mag_1;
      logic [MAG_W-1:0] band_mag_2;
      logic [MAG_W-1:0] band_mag_3;
      logic [MAG_W-1:0] band_mag_4;
      logic [31:0]      now_ms;
   } req_type;

   typedef struct packed {
      logic               beat_seen;
      logic [LEVEL_W-1:0] beat_strength;
      logic [LEVEL_W-1:0] level_0;
      logic [LEVEL_W-1:0] level_1;
      logic [LEVEL_W-1:0] level_2;
      logic [LEVEL_W-1:0] level_3;
      logic [LEVEL_W-1:0] level_4;
   } rsp_type;

   typedef struct packed {
      logic              load;
      logic              test;
      logic              decide;
      logic              div_step;
      logic [DIV_W-1:0]  div_bit;
      logic              band_mul;
      logic              band_gain;
      logic              band_clamp;
      logic [BAND_W-1:0] band;
      logic              publish;
   } cmd_type;

   typedef struct packed {
      logic need_div;
   } sts_type;

endpackage
`default_nettype wire

[rtl/bbd_agc_ram.sv]
`default_nettype none
module bbd_agc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

[rtl/bbd_agc_ctrl.sv]
`default_nettype none
module bbd_agc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire bbd_agc_pkg::sts_type sts,
   output bbd_agc_pkg::cmd_type     cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_TEST  = 3'd1;
   localparam logic [2:0] S_DEC   = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_GAIN  = 3'd5;
   localparam logic [2:0] S_CLAMP = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   localparam logic [bbd_agc_pkg::DIV_W-1:0] DIV_TOP =
      bbd_agc_pkg::DIV_W'(bbd_agc_pkg::DIV_STEPS - 1);
   localparam logic [bbd_agc_pkg::BAND_W-1:0] BAND_LAST =
      bbd_agc_pkg::BAND_W'(bbd_agc_pkg::NUM_BANDS - 1);

   logic [2:0]                       state_ff, state_in;
   logic [bbd_agc_pkg::DIV_W-1:0]    bit_ff, bit_in;
   logic [bbd_agc_pkg::BAND_W-1:0]   band_ff, band_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      bit_in    = bit_ff;
      band_in   = band_ff;
      cmd       = '0;
      cmd.div_bit = bit_ff;
      cmd.band    = band_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            cmd.test = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            cmd.decide = 1'b1;
            bit_in     = DIV_TOP;
            state_in   = S_DIV;
         end
         S_DIV: begin
            if (!sts.need_div || bit_ff == '0) begin
               band_in  = '0;
               state_in = S_MUL;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
            cmd.div_step = sts.need_div;
         end
         S_MUL: begin
            cmd.band_mul = 1'b1;
            state_in     = S_GAIN;
         end
         S_GAIN: begin
            cmd.band_gain = 1'b1;
            state_in      = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.band_clamp = 1'b1;
            if (band_ff == BAND_LAST) begin
               state_in = S_DONE;
            end else begin
               band_in  = band_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bit_ff       <= '0;
         band_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_ff       <= bit_in;
         band_ff      <= band_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.test, cmd.decide, cmd.div_step, cmd.band_mul,
                cmd.band_gain, cmd.band_clamp, cmd.publish}))
      else $error("more than one datapath command");
   a_publish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid)
      else $error("published result not shown");
   a_band_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.band_mul || cmd.band_clamp) |-> band_ff <= BAND_LAST)
      else $error("band index out of range");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_TEST)
      else $error("transfer did not start work");
`endif

endmodule
`default_nettype wire

[rtl/bbd_agc_dp.sv]
`default_nettype none
module bbd_agc_dp #(
   parameter int HISTORY_DEPTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire bbd_agc_pkg::req_type                 req_data,
   input  wire logic                                 csr_write,
   input  wire logic [bbd_agc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bbd_agc_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire bbd_agc_pkg::cmd_type                 cmd,
   output bbd_agc_pkg::sts_type                      sts,
   output bbd_agc_pkg::rsp_type                      rsp_data
);

   localparam int PW = $clog2(HISTORY_DEPTH);
   localparam int NW = $clog2(HISTORY_DEPTH + 1);
   localparam int SW = bbd_agc_pkg::MAG_W + NW;
   localparam int RW = SW + 8;
   localparam int GW = bbd_agc_pkg::GAIN_W;
   localparam int FW = bbd_agc_pkg::FACTOR_W;
   localparam int LW = bbd_agc_pkg::LEVEL_W;
   localparam int MW = bbd_agc_pkg::MAG_W;
   localparam int PRW = MW + GW;
   localparam int GPW = GW + FW;
   localparam logic [PW-1:0] POS_LAST = PW'(HISTORY_DEPTH - 1);
   localparam logic [NW-1:0] N_FULL   = NW'(HISTORY_DEPTH);

   logic [9:0]    ratio_ff;
   logic [15:0]   refr_ff, squelch_ff;
   logic [LW-1:0] target_ff;
   logic [FW-1:0] up_ff, down_ff;
   logic [GW-1:0] gmax_ff;
   logic [GW-1:0] gain_ff [bbd_agc_pkg::NUM_BANDS];

   logic [SW-1:0] sum_ff;
   logic [PW-1:0] pos_ff;
   logic          full_ff;
   logic [31:0]   last_ff;

   bbd_agc_pkg::req_type in_ff;
   logic [MW-1:0]    old_data, old_ff;
   logic [16+NW-1:0] sq_ff;
   logic [SW-1:0]    lhs_ff;
   logic [SW+9:0]    rhs_ff;
   logic             beat_ff, gt_ff, big_ff, need_ff;
   logic [RW-1:0]    rem_ff, den_ff;
   logic [LW-1:0]    q_ff;
   logic [PRW-1:0]   prod_ff;
   logic [GPW-1:0]   gprod_ff;
   logic [LW-1:0]    lvl_ff [bbd_agc_pkg::NUM_BANDS];
   bbd_agc_pkg::rsp_type out_ff;

   logic [NW-1:0]  n_val;
   logic           beat_in;
   logic [SW:0]    diff;
   logic [RW-1:0]  trial;
   logic [MW-1:0]  mag_sel;
   logic [GW-1:0]  gain_sel;
   logic [LW-1:0]  lvl_now;
   logic [FW-1:0]  factor;
   logic [GW:0]    g_raw;
   logic [GW:0]    g_lo;
   logic [GW-1:0]  g_new;
   logic [LW-1:0]  strength;

   bbd_agc_ram #(
      .WIDTH (MW),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (cmd.decide),
      .wr_addr (pos_ff),
      .wr_data (in_ff.bass_magnitude),
      .rd_en   (cmd.load),
      .rd_addr (pos_ff),
      .rd_data (old_data)
   );

   assign n_val = full_ff ? N_FULL : NW'(pos_ff);

   assign beat_in = (n_val != '0)
      && (sum_ff > SW'(sq_ff))
      && ((SW+10)'({lhs_ff, 8'd0}) > rhs_ff)
      && ((in_ff.now_ms - last_ff) > {16'd0, refr_ff});

   assign diff  = {1'b0, lhs_ff} - {1'b0, sum_ff};
   assign trial = den_ff << cmd.div_bit;

   always_comb begin
      case (cmd.band)
         3'd0:    mag_sel = in_ff.band_mag_0;
         3'd1:    mag_sel = in_ff.band_mag_1;
         3'd2:    mag_sel = in_ff.band_mag_2;
         3'd3:    mag_sel = in_ff.band_mag_3;
         default: mag_sel = in_ff.band_mag_4;
      endcase
   end

   assign gain_sel = gain_ff[cmd.band];
   assign lvl_now  = (|prod_ff[PRW-1:GW+LW]) ? bbd_agc_pkg::LEVEL_MAX
                                            : prod_ff[GW+LW-1:GW];
   assign factor   = (lvl_now < target_ff) ? up_ff : down_ff;
   assign g_raw    = gprod_ff[GPW-1:16];

   // lower clamp first, the upper clamp wins
   always_comb begin
      g_lo  = (g_raw < (GW+1)'(bbd_agc_pkg::GAIN_ONE)) ? (GW+1)'(bbd_agc_pkg::GAIN_ONE)
                                                       : g_raw;
      g_new = (g_lo > {1'b0, gmax_ff}) ? gmax_ff : g_lo[GW-1:0];
   end

   always_comb begin
      if (!beat_ff) begin
         strength = '0;
      end else if (!gt_ff) begin
         strength = bbd_agc_pkg::STRENGTH_MIN;
      end else if (big_ff) begin
         strength = bbd_agc_pkg::STRENGTH_MAX;
      end else if (q_ff < bbd_agc_pkg::STRENGTH_MIN) begin
         strength = bbd_agc_pkg::STRENGTH_MIN;
      end else begin
         strength = q_ff;
      end
   end

   assign sts.need_div = need_ff;
   assign rsp_data     = out_ff;

   // configuration and state that reset defines
   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff   <= bbd_agc_pkg::RST_THRESHOLD_RATIO;
         refr_ff    <= bbd_agc_pkg::RST_REFRACTORY_MS;
         squelch_ff <= bbd_agc_pkg::RST_SQUELCH_LEVEL;
         target_ff  <= bbd_agc_pkg::RST_LEVEL_TARGET;
         up_ff      <= bbd_agc_pkg::RST_GAIN_UP;
         down_ff    <= bbd_agc_pkg::RST_GAIN_DOWN;
         gmax_ff    <= bbd_agc_pkg::RST_GAIN_MAX;
         for (int b = 0; b < bbd_agc_pkg::NUM_BANDS; b++) begin
            gain_ff[b] <= bbd_agc_pkg::RST_GAIN_INITIAL;
         end
         sum_ff  <= '0;
         pos_ff  <= '0;
         full_ff <= 1'b0;
         last_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               bbd_agc_pkg::REG_THRESHOLD_RATIO: ratio_ff   <= csr_data[9:0];
               bbd_agc_pkg::REG_REFRACTORY_MS:   refr_ff    <= csr_data[15:0];
               bbd_agc_pkg::REG_SQUELCH_LEVEL:   squelch_ff <= csr_data[15:0];
               bbd_agc_pkg::REG_LEVEL_TARGET:    target_ff  <= csr_data[LW-1:0];
               bbd_agc_pkg::REG_GAIN_UP:         up_ff      <= csr_data[FW-1:0];
               bbd_agc_pkg::REG_GAIN_DOWN:       down_ff    <= csr_data[FW-1:0];
               bbd_agc_pkg::REG_GAIN_MAX:        gmax_ff    <= csr_data;
               bbd_agc_pkg::REG_GAIN_INITIAL: begin
                  for (int b = 0; b < bbd_agc_pkg::NUM_BANDS; b++) begin
                     gain_ff[b] <= csr_data;
                  end
               end
               default: begin
               end
            endcase
         end
         if (cmd.decide) begin
            sum_ff <= sum_ff - (full_ff ? SW'(old_ff) : '0)
                      + SW'(in_ff.bass_magnitude);
            if (pos_ff == POS_LAST) begin
               pos_ff  <= '0;
               full_ff <= 1'b1;
            end else begin
               pos_ff <= pos_ff + 1'b1;
            end
            if (beat_in) begin
               last_ff <= in_ff.now_ms;
            end
         end
         if (cmd.band_clamp) begin
            gain_ff[cmd.band] <= g_new;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         need_ff <= 1'b0;
      end else if (cmd.decide) begin
         need_ff <= beat_in && !diff[SW] && (diff != '0)
                    && (diff < {sum_ff, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_ff <= req_data;
      end
      if (cmd.test) begin
         old_ff <= old_data;
         sq_ff  <= squelch_ff * n_val;
         lhs_ff <= in_ff.bass_magnitude * n_val;
         rhs_ff <= sum_ff * ratio_ff;
      end
      if (cmd.decide) begin
         beat_ff <= beat_in;
         gt_ff   <= !diff[SW] && (diff != '0);
         big_ff  <= diff >= {sum_ff, 1'b0};
         rem_ff  <= RW'({diff, 7'd0});
         den_ff  <= RW'(sum_ff);
         q_ff    <= '0;
      end
      if (cmd.div_step && rem_ff >= trial) begin
         rem_ff            <= rem_ff - trial;
         q_ff[cmd.div_bit] <= 1'b1;
      end
      if (cmd.band_mul) begin
         prod_ff <= mag_sel * gain_sel;
      end
      if (cmd.band_gain) begin
         lvl_ff[cmd.band] <= lvl_now;
         gprod_ff         <= gain_sel * factor;
      end
      if (cmd.publish) begin
         out_ff.beat_seen     <= beat_ff;
         out_ff.beat_strength <= strength;
         out_ff.level_0       <= lvl_ff[0];
         out_ff.level_1       <= lvl_ff[1];
         out_ff.level_2       <= lvl_ff[2];
         out_ff.level_3       <= lvl_ff[3];
         out_ff.level_4       <= lvl_ff[4];
      end
   end

endmodule
`default_nettype wire

[rtl/bass_beat_detector_band_agc_unit.sv]
// bass beat detector with per-band gain control
// req channel: one transfer per audio frame carrying the bass magnitude, five
// octave band magnitudes and a millisecond timestamp
// rsp channel: one transfer per frame with the beat flag, beat strength and
// five gained band levels
// csr channel: register index and data, always ready, write only while idle
// after a req transfer loads the frame, the test and decide steps run; the
// bit-serial strength divider then steps through the quotient bits only when
// a beat needs a division, and the five bands pass in turn through shared
// multipliers in multiply, gain and clamp steps; then the result is published
// a new frame is taken while the previous result still waits in the output
// register; a stalled rsp holds the result, and the next frame then finishes
// and waits until the output register frees up
// reset: synchronous, clears the history count, sum and last beat time,
// restores register defaults and loads the initial gain into every band;
// history entries are used only after they have been written
`default_nettype none
module bass_beat_detector_band_agc_unit #(
   parameter int HISTORY_DEPTH = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire bbd_agc_pkg::req_type               req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output bbd_agc_pkg::rsp_type                    rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [bbd_agc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bbd_agc_pkg::CSR_DATA_W-1:0] csr_data
);

   bbd_agc_pkg::cmd_type cmd;
   bbd_agc_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   bbd_agc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bbd_agc_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
